/* design/rtdp_pkg.sv */
// Shared types, constants and helper functions for the RGB to display pixel converter.
package rtdp_pkg;

    localparam int PALETTE_DEPTH = 256;
    localparam int PAL_AW        = $clog2(PALETTE_DEPTH);

    localparam int CH_W      = 8;
    localparam int LVL_W     = 9;
    localparam int PIX_W     = 32;
    localparam int ENTRY_W   = 8;
    localparam int CFG_IDX_W = 4;
    localparam int SUM_W     = 10;
    localparam int Q_W       = 9;
    localparam int A_W       = 18;
    localparam int IDX_W     = 27;

    // y = sum / 3 as (sum * 683) >> 11, exact for sums up to 765
    localparam int DIV3_MUL  = 683;
    localparam int DIV3_SH   = 11;
    localparam int DIV3_PW   = 19;

    typedef enum logic [1:0] {
        DISP_GRAY    = 2'd0,
        DISP_INDEXED = 2'd1,
        DISP_DIRECT  = 2'd2
    } disp_mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DISPLAY_MODE = 4'd0,
        CFG_RED_MASK     = 4'd1,
        CFG_GREEN_MASK   = 4'd2,
        CFG_BLUE_MASK    = 4'd3,
        CFG_RED_LEVELS   = 4'd4,
        CFG_GREEN_LEVELS = 4'd5,
        CFG_BLUE_LEVELS  = 4'd6,
        CFG_GRAY_LEVELS  = 4'd7
    } cfg_reg_t;

    localparam logic [PIX_W-1:0] RST_RED_MASK     = 32'h00FF_0000;
    localparam logic [PIX_W-1:0] RST_GREEN_MASK   = 32'h0000_FF00;
    localparam logic [PIX_W-1:0] RST_BLUE_MASK    = 32'h0000_00FF;
    localparam logic [LVL_W-1:0] RST_RED_LEVELS   = 9'd6;
    localparam logic [LVL_W-1:0] RST_GREEN_LEVELS = 9'd6;
    localparam logic [LVL_W-1:0] RST_BLUE_LEVELS  = 9'd7;
    localparam logic [LVL_W-1:0] RST_GRAY_LEVELS  = 9'd256;

    typedef struct packed {
        logic              en;
        logic [PAL_AW-1:0] addr;
        logic [PIX_W-1:0]  data;
    } pal_wr_t;

    typedef struct packed {
        logic              en;
        logic [PAL_AW-1:0] addr;
    } pal_rd_t;

    // Keeps only the lowest run of ones of a mask
    function automatic logic [PIX_W-1:0] lowest_run(input logic [PIX_W-1:0] m);
        logic [PIX_W-1:0] low;
        low = m & (~m + 32'd1);
        return m & ~(m + low);
    endfunction

    // Index of the highest set bit (0 for an empty word)
    function automatic logic [4:0] top_bit(input logic [PIX_W-1:0] v);
        logic [4:0] r;
        r = '0;
        for (int i = 0; i < PIX_W; i++)
        begin
            if (v[i])
            begin
                r = 5'(i);
            end
        end
        return r;
    endfunction

    // Places a channel with its msb on the field's top bit, clipped to the field
    function automatic logic [PIX_W-1:0] field_place(input logic [CH_W-1:0] c,
                                                     input logic [4:0] t,
                                                     input logic [PIX_W-1:0] run);
        logic [CH_W+PIX_W-1:0] w;
        logic [5:0]            sh;
        sh = 6'd39 - {1'b0, t};
        w  = {c, {PIX_W{1'b0}}} >> sh;
        return w[PIX_W-1:0] & run;
    endfunction

endpackage

/* design/rtdp_palette.sv */
// Palette memory: one write port, one read port with registered read word.
module rtdp_palette
    import rtdp_pkg::*;
(
    input  logic             clk,
    input  pal_wr_t          wr,
    input  pal_rd_t          rd,
    output logic [PIX_W-1:0] rd_data
);

    logic [PIX_W-1:0] mem [PALETTE_DEPTH];
    logic [PIX_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/rgb_to_display_pixel.sv */
// Top level of the RGB to display pixel converter: config registers and five-stage pipeline.
//
// Usage notes:
//   sample channel (sample_valid/sample_ready): one word per accepted item. mode 0
//     converts red/green/blue, mode 1 writes entry_value into palette entry
//     entry_index and gives no result.
//   result channel (result_valid/result_ready): pixel and out_of_range for every
//     converted word, in order.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready; write only
//     while no word is in flight. Indexes beyond the register list are ignored.
//   A result is shown from the stage-5 output register (five register stages, the
//     palette read registered between stages 3 and 4).
//   Throughput: one word per cycle while result_ready holds; stages are set by the
//     multipliers in the indexed path (level and cube products) and the palette read port.
//   A palette load writes its entry as it leaves stage 3, before any later sample
//     reaches the read port, so a convert may follow a load at once.
//   Reset: config registers return to their defaults, the pipeline empties; the
//     palette keeps whatever it held and must be loaded before use.
//   Receiver stall: each stage holds its word while the one after it is full and held;
//     sample_ready falls only when all five stages are occupied.
module rgb_to_display_pixel
    import rtdp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 sample_valid,
    output logic                 sample_ready,
    input  logic                 mode,
    input  logic [CH_W-1:0]      red,
    input  logic [CH_W-1:0]      green,
    input  logic [CH_W-1:0]      blue,
    input  logic [ENTRY_W-1:0]   entry_index,
    input  logic [PIX_W-1:0]     entry_value,

    output logic                 result_valid,
    input  logic                 result_ready,
    output logic [PIX_W-1:0]     pixel,
    output logic                 out_of_range,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PIX_W-1:0]     cfg_data
);

    // configuration
    logic [1:0]       display_mode_reg;
    logic [PIX_W-1:0] red_mask_reg, green_mask_reg, blue_mask_reg;
    logic [LVL_W-1:0] red_levels_reg, green_levels_reg, blue_levels_reg, gray_levels_reg;

    // stage enables
    logic en1, en2, en3, en4, en5;

    // stage 1
    logic               s1_valid_reg, s1_load_reg;
    logic [CH_W-1:0]    s1_red_reg, s1_green_reg, s1_blue_reg;
    logic [ENTRY_W-1:0] s1_entry_index_reg;
    logic [PIX_W-1:0]   s1_entry_value_reg;
    logic [SUM_W-1:0]   s1_sum_reg, s1_sum_next;
    logic [Q_W-1:0]     s1_qr_reg, s1_qg_reg, s1_qb_reg;
    logic [Q_W-1:0]     s1_qr_next, s1_qg_next, s1_qb_next;
    logic [PIX_W-1:0]   s1_run_r_reg, s1_run_g_reg, s1_run_b_reg;
    logic [16:0]        prod_r, prod_g, prod_b;

    // stage 2
    logic               s2_valid_reg, s2_load_reg;
    logic [CH_W-1:0]    s2_red_reg, s2_green_reg, s2_blue_reg;
    logic [ENTRY_W-1:0] s2_entry_index_reg;
    logic [PIX_W-1:0]   s2_entry_value_reg;
    logic [CH_W-1:0]    s2_y_reg, s2_y_next;
    logic [A_W-1:0]     s2_a_reg, s2_a_next;
    logic [Q_W-1:0]     s2_qb_reg;
    logic [PIX_W-1:0]   s2_run_r_reg, s2_run_g_reg, s2_run_b_reg;
    logic [4:0]         s2_t_r_reg, s2_t_g_reg, s2_t_b_reg;
    logic [DIV3_PW-1:0] y_prod;

    // stage 3
    logic               s3_valid_reg, s3_load_reg;
    logic [ENTRY_W-1:0] s3_entry_index_reg;
    logic [PIX_W-1:0]   s3_entry_value_reg;
    logic [Q_W-1:0]     s3_gq_reg, s3_gq_next, s3_qb_reg;
    logic [IDX_W-1:0]   s3_p_reg, s3_p_next;
    logic [PIX_W-1:0]   s3_fr_reg, s3_fg_reg, s3_fb_reg;
    logic [16:0]        gq_prod;

    // stage 4
    logic               s4_valid_reg, s4_oor_reg, s4_oor_next;
    logic [PIX_W-1:0]   s4_direct_reg, s4_direct_next;
    logic [IDX_W-1:0]   pal_idx;
    pal_wr_t            pal_wr;
    pal_rd_t            pal_rd;
    logic [PIX_W-1:0]   pal_data;

    // stage 5 (output register)
    logic               s5_valid_reg;
    logic [PIX_W-1:0]   pixel_reg, pixel_next;
    logic               oor_reg, oor_next;

    // ---------------- configuration port ----------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            display_mode_reg <= DISP_DIRECT;
            red_mask_reg     <= RST_RED_MASK;
            green_mask_reg   <= RST_GREEN_MASK;
            blue_mask_reg    <= RST_BLUE_MASK;
            red_levels_reg   <= RST_RED_LEVELS;
            green_levels_reg <= RST_GREEN_LEVELS;
            blue_levels_reg  <= RST_BLUE_LEVELS;
            gray_levels_reg  <= RST_GRAY_LEVELS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_DISPLAY_MODE: display_mode_reg <= cfg_data[1:0];
                CFG_RED_MASK:     red_mask_reg     <= cfg_data;
                CFG_GREEN_MASK:   green_mask_reg   <= cfg_data;
                CFG_BLUE_MASK:    blue_mask_reg    <= cfg_data;
                CFG_RED_LEVELS:   red_levels_reg   <= cfg_data[LVL_W-1:0];
                CFG_GREEN_LEVELS: green_levels_reg <= cfg_data[LVL_W-1:0];
                CFG_BLUE_LEVELS:  blue_levels_reg  <= cfg_data[LVL_W-1:0];
                CFG_GRAY_LEVELS:  gray_levels_reg  <= cfg_data[LVL_W-1:0];
                default:          ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    always_comb
    begin
        en5 = !s5_valid_reg || result_ready;
        en4 = !s4_valid_reg || en5;
        en3 = !s3_valid_reg || en4;
        en2 = !s2_valid_reg || en3;
        en1 = !s1_valid_reg || en2;
    end

    assign sample_ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= sample_valid;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (en4)
            begin
                // load words retire here after writing the palette
                s4_valid_reg <= s3_valid_reg && !s3_load_reg;
            end
            if (en5)
            begin
                s5_valid_reg <= s4_valid_reg;
            end
        end
    end

    // ---------------- stage 1: channel sum, level products, mask runs ----------------
    always_comb
    begin
        s1_sum_next = {2'b00, red} + {2'b00, green} + {2'b00, blue};
        prod_r      = 17'(red) * 17'(red_levels_reg);
        prod_g      = 17'(green) * 17'(green_levels_reg);
        prod_b      = 17'(blue) * 17'(blue_levels_reg);
        s1_qr_next  = prod_r[16:8];
        s1_qg_next  = prod_g[16:8];
        s1_qb_next  = prod_b[16:8];
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_load_reg        <= mode;
            s1_red_reg         <= red;
            s1_green_reg       <= green;
            s1_blue_reg        <= blue;
            s1_entry_index_reg <= entry_index;
            s1_entry_value_reg <= entry_value;
            s1_sum_reg         <= s1_sum_next;
            s1_qr_reg          <= s1_qr_next;
            s1_qg_reg          <= s1_qg_next;
            s1_qb_reg          <= s1_qb_next;
            s1_run_r_reg       <= lowest_run(red_mask_reg);
            s1_run_g_reg       <= lowest_run(green_mask_reg);
            s1_run_b_reg       <= lowest_run(blue_mask_reg);
        end
    end

    // ---------------- stage 2: average, partial cube index, field tops ----------------
    always_comb
    begin
        y_prod    = DIV3_PW'(s1_sum_reg) * DIV3_PW'(DIV3_MUL);
        s2_y_next = y_prod[DIV3_SH+CH_W-1:DIV3_SH];
        s2_a_next = A_W'(s1_qr_reg) * A_W'(green_levels_reg) + A_W'(s1_qg_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_load_reg        <= s1_load_reg;
            s2_red_reg         <= s1_red_reg;
            s2_green_reg       <= s1_green_reg;
            s2_blue_reg        <= s1_blue_reg;
            s2_entry_index_reg <= s1_entry_index_reg;
            s2_entry_value_reg <= s1_entry_value_reg;
            s2_y_reg           <= s2_y_next;
            s2_a_reg           <= s2_a_next;
            s2_qb_reg          <= s1_qb_reg;
            s2_run_r_reg       <= s1_run_r_reg;
            s2_run_g_reg       <= s1_run_g_reg;
            s2_run_b_reg       <= s1_run_b_reg;
            s2_t_r_reg         <= top_bit(s1_run_r_reg);
            s2_t_g_reg         <= top_bit(s1_run_g_reg);
            s2_t_b_reg         <= top_bit(s1_run_b_reg);
        end
    end

    // ---------------- stage 3: gray index, cube product, field placement ----------------
    always_comb
    begin
        gq_prod    = 17'(s2_y_reg) * 17'(gray_levels_reg);
        s3_gq_next = gq_prod[16:8];
        s3_p_next  = IDX_W'(s2_a_reg) * IDX_W'(blue_levels_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            s3_load_reg        <= s2_load_reg;
            s3_entry_index_reg <= s2_entry_index_reg;
            s3_entry_value_reg <= s2_entry_value_reg;
            s3_gq_reg          <= s3_gq_next;
            s3_p_reg           <= s3_p_next;
            s3_qb_reg          <= s2_qb_reg;
            s3_fr_reg          <= field_place(s2_red_reg, s2_t_r_reg, s2_run_r_reg);
            s3_fg_reg          <= field_place(s2_green_reg, s2_t_g_reg, s2_run_g_reg);
            s3_fb_reg          <= field_place(s2_blue_reg, s2_t_b_reg, s2_run_b_reg);
        end
    end

    // ---------------- stage 4: palette access, direct packing ----------------
    always_comb
    begin
        if (display_mode_reg == DISP_GRAY)
        begin
            pal_idx = IDX_W'(s3_gq_reg);
        end
        else
        begin
            pal_idx = s3_p_reg + IDX_W'(s3_qb_reg);
        end
        s4_oor_next    = (pal_idx >= IDX_W'(PALETTE_DEPTH));
        s4_direct_next = s3_fr_reg + s3_fg_reg + s3_fb_reg;

        pal_rd.en   = en4 && s3_valid_reg && !s3_load_reg;
        pal_rd.addr = pal_idx[PAL_AW-1:0];

        pal_wr.en   = en4 && s3_valid_reg && s3_load_reg &&
                      (IDX_W'(s3_entry_index_reg) < IDX_W'(PALETTE_DEPTH));
        pal_wr.addr = PAL_AW'(s3_entry_index_reg);
        pal_wr.data = s3_entry_value_reg;
    end

    rtdp_palette u_palette
    (
        .clk     (clk),
        .wr      (pal_wr),
        .rd      (pal_rd),
        .rd_data (pal_data)
    );

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            s4_oor_reg    <= s4_oor_next;
            s4_direct_reg <= s4_direct_next;
        end
    end

    // ---------------- stage 5: result select ----------------
    always_comb
    begin
        case (display_mode_reg)
            DISP_GRAY, DISP_INDEXED:
            begin
                pixel_next = s4_oor_reg ? '0 : pal_data;
                oor_next   = s4_oor_reg;
            end
            DISP_DIRECT:
            begin
                pixel_next = s4_direct_reg;
                oor_next   = 1'b0;
            end
            default:
            begin
                pixel_next = '0;
                oor_next   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            pixel_reg <= pixel_next;
            oor_reg   <= oor_next;
        end
    end

    assign result_valid = s5_valid_reg;
    assign pixel        = pixel_reg;
    assign out_of_range = oor_reg;

    // ---------------- assertions ----------------
    a_oor_zero_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && out_of_range |-> pixel == '0)
        else $error("out-of-range word carries a non-zero pixel");

    a_oor_palette_mode: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && out_of_range |->
            display_mode_reg == DISP_GRAY || display_mode_reg == DISP_INDEXED)
        else $error("out-of-range flagged outside palette modes");

    a_stall_full_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        !sample_ready |-> s1_valid_reg && s2_valid_reg && s3_valid_reg &&
                          s4_valid_reg && s5_valid_reg && !result_ready)
        else $error("input stalled while the pipeline has a bubble");

endmodule

/* tb/rgb_to_display_pixel_tb.sv */
// Self-checking testbench for the RGB to display pixel converter.
module rgb_to_display_pixel_tb;
    import rtdp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASES       = 16;
    localparam int PHASE_WORDS  = 33;
    localparam int IDLE_PCT     = 29;

    localparam logic             MODE_CONVERT = 1'b0;
    localparam logic             MODE_LOAD    = 1'b1;
    localparam logic [1:0]       DISP_UNUSED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NONE = 4'd15;

    typedef struct packed {
        logic               mode;
        logic [CH_W-1:0]    red;
        logic [CH_W-1:0]    green;
        logic [CH_W-1:0]    blue;
        logic [ENTRY_W-1:0] entry_index;
        logic [PIX_W-1:0]   entry_value;
    } colour_word_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             out_of_range;
    } display_pixel_t;

    class pixel_tracker;
        logic [1:0]       disp_sel;
        logic [PIX_W-1:0] mask_r, mask_g, mask_b;
        logic [LVL_W-1:0] lvl_r, lvl_g, lvl_b, lvl_y;
        logic [PIX_W-1:0] palette [PALETTE_DEPTH];
        display_pixel_t   pending_pixels [$];
        int               failures;

        function new();
            disp_sel = DISP_DIRECT;
            mask_r   = RST_RED_MASK;
            mask_g   = RST_GREEN_MASK;
            mask_b   = RST_BLUE_MASK;
            lvl_r    = RST_RED_LEVELS;
            lvl_g    = RST_GREEN_LEVELS;
            lvl_b    = RST_BLUE_LEVELS;
            lvl_y    = RST_GRAY_LEVELS;
            failures = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [PIX_W-1:0] d);
            case (idx)
                CFG_DISPLAY_MODE: disp_sel = d[1:0];
                CFG_RED_MASK:     mask_r   = d;
                CFG_GREEN_MASK:   mask_g   = d;
                CFG_BLUE_MASK:    mask_b   = d;
                CFG_RED_LEVELS:   lvl_r    = d[LVL_W-1:0];
                CFG_GREEN_LEVELS: lvl_g    = d[LVL_W-1:0];
                CFG_BLUE_LEVELS:  lvl_b    = d[LVL_W-1:0];
                CFG_GRAY_LEVELS:  lvl_y    = d[LVL_W-1:0];
                default: ;
            endcase
        endfunction

        // channel scaled to the lowest run of the mask, msb on the run's top bit
        function logic [PIX_W-1:0] pack_channel(logic [CH_W-1:0] c, logic [PIX_W-1:0] m);
            int               lo;
            int               n;
            logic [PIX_W-1:0] v;
            if (m == '0)
                return '0;
            lo = 0;
            while (!m[lo])
                lo++;
            n = 0;
            while (lo + n < PIX_W && m[lo + n])
                n++;
            if (n <= CH_W)
                v = PIX_W'(c) >> (CH_W - n);
            else
                v = PIX_W'(c) << (n - CH_W);
            return v << lo;
        endfunction

        function longint unsigned level_of(logic [CH_W-1:0] c, logic [LVL_W-1:0] l);
            return (longint'(c) * longint'(l)) >> 8;
        endfunction

        function display_pixel_t look_up(longint unsigned idx);
            display_pixel_t r;
            if (idx >= PALETTE_DEPTH)
            begin
                r.pixel        = '0;
                r.out_of_range = 1'b1;
            end
            else
            begin
                r.pixel        = palette[idx];
                r.out_of_range = 1'b0;
            end
            return r;
        endfunction

        function display_pixel_t convert_colour(colour_word_t w);
            display_pixel_t   r;
            longint unsigned  y;
            longint unsigned  idx;
            r = '0;
            case (disp_sel)
                DISP_GRAY:
                begin
                    y = (longint'(w.red) + w.green + w.blue) / 3;
                    r = look_up(level_of(CH_W'(y), lvl_y));
                end
                DISP_INDEXED:
                begin
                    idx = level_of(w.red, lvl_r) * lvl_g * lvl_b
                        + level_of(w.green, lvl_g) * lvl_b
                        + level_of(w.blue, lvl_b);
                    r = look_up(idx);
                end
                DISP_DIRECT:
                    r.pixel = pack_channel(w.red, mask_r) + pack_channel(w.green, mask_g)
                            + pack_channel(w.blue, mask_b);
                default: ;
            endcase
            return r;
        endfunction

        function void take_word(colour_word_t w);
            if (w.mode == MODE_LOAD)
                palette[w.entry_index] = w.entry_value;
            else
                pending_pixels.push_back(convert_colour(w));
        endfunction

        function void check_pixel(logic [PIX_W-1:0] pix, logic oor);
            display_pixel_t e;
            if (pending_pixels.size() == 0)
            begin
                $display("%0t: unexpected word, pixel %h out_of_range %b", $time, pix, oor);
                failures++;
                return;
            end
            e = pending_pixels.pop_front();
            if (pix !== e.pixel)
            begin
                $display("%0t: pixel expected %h actual %h", $time, e.pixel, pix);
                failures++;
            end
            if (oor !== e.out_of_range)
            begin
                $display("%0t: out_of_range expected %b actual %b", $time, e.out_of_range, oor);
                failures++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 sample_valid;
    logic                 sample_ready;
    logic                 mode;
    logic [CH_W-1:0]      red;
    logic [CH_W-1:0]      green;
    logic [CH_W-1:0]      blue;
    logic [ENTRY_W-1:0]   entry_index;
    logic [PIX_W-1:0]     entry_value;
    logic                 result_valid;
    logic                 result_ready;
    logic [PIX_W-1:0]     pixel;
    logic                 out_of_range;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [PIX_W-1:0]     cfg_data;

    pixel_tracker tracker = new();
    bit           steady  = 1'b0;
    int           cycles  = 0;

    rgb_to_display_pixel dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .mode         (mode),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .entry_index  (entry_index),
        .entry_value  (entry_value),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .pixel        (pixel),
        .out_of_range (out_of_range),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        result_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            tracker.check_pixel(pixel, out_of_range);
    end

    function automatic colour_word_t colour(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                                            logic [CH_W-1:0] b);
        colour_word_t w;
        w             = '0;
        w.mode        = MODE_CONVERT;
        w.red         = r;
        w.green       = g;
        w.blue        = b;
        w.entry_index = ENTRY_W'($urandom());
        w.entry_value = $urandom();
        return w;
    endfunction

    function automatic colour_word_t entry(logic [ENTRY_W-1:0] i, logic [PIX_W-1:0] v);
        colour_word_t w;
        w             = colour(CH_W'($urandom()), CH_W'($urandom()), CH_W'($urandom()));
        w.mode        = MODE_LOAD;
        w.entry_index = i;
        w.entry_value = v;
        return w;
    endfunction

    function automatic logic [CH_W-1:0] rand_channel();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return CH_W'($urandom());
        endcase
    endfunction

    function automatic colour_word_t rand_word();
        if ($urandom_range(0, 99) < 15)
            return entry(ENTRY_W'($urandom()), $urandom());
        return colour(rand_channel(), rand_channel(), rand_channel());
    endfunction

    function automatic logic [PIX_W-1:0] rand_mask();
        int lo;
        int n;
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return $urandom();   // scattered bits, only the lowest run counts
            default:
            begin
                lo = $urandom_range(0, PIX_W - 1);
                n  = $urandom_range(1, PIX_W - lo);
                return PIX_W'(((64'd1 << n) - 64'd1) << lo);
            end
        endcase
    endfunction

    function automatic logic [PIX_W-1:0] rand_levels();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return 1;
            2: return 2;
            3: return 256;
            4: return 511;
            5: return $urandom_range(0, 511);
            default: return $urandom_range(2, 8);
        endcase
    endfunction

    // enters on a falling edge, leaves on the falling edge after acceptance
    task automatic send_word(input colour_word_t w);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            sample_valid <= 1'b0;
            @(negedge clk);
        end
        sample_valid <= 1'b1;
        mode         <= w.mode;
        red          <= w.red;
        green        <= w.green;
        blue         <= w.blue;
        entry_index  <= w.entry_index;
        entry_value  <= w.entry_value;
        do
            @(posedge clk);
        while (!sample_ready);
        tracker.take_word(w);
        @(negedge clk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PIX_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do
            @(posedge clk);
        while (!cfg_ready);
        tracker.write_reg(idx, d);
        @(negedge clk);
    endtask

    // loads still in flight give no result, hence the extra cycles
    task automatic quiesce();
        sample_valid <= 1'b0;
        while (tracker.pending_pixels.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES)
            @(negedge clk);
    endtask

    task automatic random_setup();
        int sel;
        sel = $urandom_range(0, 9);
        set_reg(CFG_DISPLAY_MODE, PIX_W'(sel < 3 ? DISP_GRAY : sel < 6 ? DISP_INDEXED :
                                          sel < 9 ? DISP_DIRECT : DISP_UNUSED));
        set_reg(CFG_RED_MASK, rand_mask());
        set_reg(CFG_GREEN_MASK, rand_mask());
        set_reg(CFG_BLUE_MASK, rand_mask());
        set_reg(CFG_RED_LEVELS, rand_levels());
        set_reg(CFG_GREEN_LEVELS, rand_levels());
        set_reg(CFG_BLUE_LEVELS, rand_levels());
        set_reg(CFG_GRAY_LEVELS, rand_levels());
        if ($urandom_range(0, 3) == 0)
            set_reg(CFG_NONE, $urandom());
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        rst_n        = 1'b0;
        sample_valid = 1'b0;
        mode         = MODE_CONVERT;
        red          = '0;
        green        = '0;
        blue         = '0;
        entry_index  = '0;
        entry_value  = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // every palette entry is loaded before any lookup
        for (int i = 0; i < PALETTE_DEPTH; i++)
            send_word(entry(ENTRY_W'(i), $urandom()));

        // direct packing with reset masks
        send_word(colour(8'h00, 8'h00, 8'h00));
        send_word(colour(8'hFF, 8'hFF, 8'hFF));
        send_word(colour(8'hFF, 8'h00, 8'h00));
        send_word(colour(8'h00, 8'hFF, 8'h00));
        send_word(colour(8'h00, 8'h00, 8'hFF));
        send_word(colour(8'h80, 8'h7F, 8'h01));
        quiesce();

        set_reg(CFG_DISPLAY_MODE, PIX_W'(DISP_GRAY));
        cfg_valid <= 1'b0;
        send_word(colour(8'h00, 8'h00, 8'h00));
        send_word(colour(8'hFF, 8'hFF, 8'hFF));
        send_word(colour(8'h02, 8'h01, 8'h00));
        send_word(colour(8'hFF, 8'hFF, 8'hFE));
        // load followed by the next word reading the same entry
        send_word(entry(8'h00, $urandom()));
        send_word(colour(8'h00, 8'h00, 8'h00));
        quiesce();

        set_reg(CFG_GRAY_LEVELS, 511);
        cfg_valid <= 1'b0;
        send_word(colour(8'hFF, 8'hFF, 8'hFF));
        send_word(colour(8'h00, 8'h00, 8'h00));
        quiesce();

        set_reg(CFG_DISPLAY_MODE, PIX_W'(DISP_INDEXED));
        cfg_valid <= 1'b0;
        send_word(colour(8'hFF, 8'hFF, 8'hFF));
        send_word(colour(8'h00, 8'h00, 8'h00));
        send_word(colour(8'hFF, 8'h00, 8'h80));
        quiesce();

        set_reg(CFG_RED_LEVELS, 256);
        set_reg(CFG_GREEN_LEVELS, 256);
        set_reg(CFG_BLUE_LEVELS, 256);
        cfg_valid <= 1'b0;
        send_word(colour(8'hFF, 8'hFF, 8'hFF));
        send_word(colour(8'h00, 8'h00, 8'h01));
        quiesce();

        set_reg(CFG_DISPLAY_MODE, PIX_W'(DISP_UNUSED));
        set_reg(CFG_NONE, '1);
        cfg_valid <= 1'b0;
        send_word(colour(8'h11, 8'h22, 8'h33));
        quiesce();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            steady = (ph == 5 || ph == 6);
            random_setup();
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                if (ph == 9 && n == PHASE_WORDS / 2)
                    quiesce();
                send_word(rand_word());
            end
            quiesce();
        end

        if (tracker.failures == 0 && tracker.pending_pixels.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
